@@ rtl/sm4_pkg.sv @@
package sm4_pkg;

	localparam int WORD_W    = 32;
	localparam int DATA_W    = 4 * WORD_W;
	localparam int ROUNDS    = 32;
	localparam int RK_AW     = $clog2(ROUNDS);
	localparam int KEY_WORDS = 4;
	localparam int CFG_IDX_W = $clog2(KEY_WORDS);

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [RK_AW-1:0]  rk_addr_t;

	localparam word_t FK [KEY_WORDS] = '{
		32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
	};

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic word_t rotl(input word_t v, input int n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	// byte-wise S-box substitution
	function automatic word_t tau(input word_t v);
		word_t r;
		for (int b = 0; b < 4; b++) begin
			r[8*b +: 8] = SBOX[v[8*b +: 8]];
		end
		return r;
	endfunction

	function automatic word_t lin_data(input word_t b);
		return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	function automatic word_t lin_key(input word_t b);
		return b ^ rotl(b, 13) ^ rotl(b, 23);
	endfunction

	// byte j of CK word i is (4i+j)*7 mod 256, byte 0 most significant
	function automatic word_t ck_word(input rk_addr_t i);
		word_t w;
		logic [RK_AW+1:0] idx;
		for (int j = 0; j < 4; j++) begin
			idx = {i, 2'(j)};
			w[8*(3-j) +: 8] = 8'(idx * 7);
		end
		return w;
	endfunction

endpackage

@@ rtl/sm4_ram.sv @@
module sm4_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/sm4_block_cipher.sv @@
// SM4 block cipher, ECB. A taken block passes the FETCH state, which reads the
// first round key from the round-key RAM, then runs one round per cycle through
// a single S-box layer shared with the key schedule (32 rounds), then loads the
// output register in the DONE state once that register is free. The first block
// after reset or after any key register write first runs the key schedule on the
// same S-box layer, with its own linear map, writing one round key per cycle into
// the RAM. The round-key RAM read port, one key per cycle, sets the round rate.
// A finished result waits in the output register while the next block is taken.
module sm4_block_cipher (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// block_word0, block_word1, block_word2, block_word3
	input  logic [sm4_pkg::DATA_W-1:0]     s_tdata,
	// decrypt
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// result_word0, result_word1, result_word2, result_word3
	output logic [sm4_pkg::DATA_W-1:0]     m_tdata,
	input  logic                           cfg_we,
	input  logic [sm4_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sm4_pkg::WORD_W-1:0]     cfg_data
);

	import sm4_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_FETCH,
		ST_ROUND,
		ST_DONE
	} state_t;

	state_t               state_q;
	rk_addr_t             cnt_q;
	logic                 keys_ready_q;
	logic                 dec_q;
	logic                 m_tvalid_q;
	logic [DATA_W-1:0]    m_tdata_q;
	word_t                key_q [KEY_WORDS];
	word_t                k_q [4];
	word_t                x_q [4];

	rk_addr_t             cnt_nxt;
	rk_addr_t             rk_raddr;
	word_t                rk_rdata;
	word_t                sub_in;
	word_t                sub_out;
	word_t                k_new;
	word_t                x_new;

	assign cnt_nxt = cnt_q + 1'b1;

	// shared round unit: key schedule and data rounds use the same S-box layer
	always_comb begin
		if (state_q == ST_EXPAND) begin
			sub_in = k_q[1] ^ k_q[2] ^ k_q[3] ^ ck_word(cnt_q);
		end else begin
			sub_in = x_q[1] ^ x_q[2] ^ x_q[3] ^ rk_rdata;
		end
	end

	assign sub_out = tau(sub_in);
	assign k_new   = k_q[0] ^ lin_key(sub_out);
	assign x_new   = x_q[0] ^ lin_data(sub_out);

	// fetch the key one round ahead; decrypt walks the keys backward
	always_comb begin
		if (state_q == ST_FETCH) begin
			rk_raddr = dec_q ? ~rk_addr_t'(0) : rk_addr_t'(0);
		end else begin
			rk_raddr = dec_q ? ~cnt_nxt : cnt_nxt;
		end
	end

	sm4_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ROUNDS)
	) u_rk_ram (
		.clk   (clk),
		.we    (state_q == ST_EXPAND),
		.waddr (cnt_q),
		.wdata (k_new),
		.raddr (rk_raddr),
		.rdata (rk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KEY_WORDS; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_we) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			keys_ready_q <= 1'b0;
			dec_q        <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			for (int i = 0; i < 4; i++) begin
				k_q[i] <= '0;
				x_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						dec_q <= s_tuser;
						cnt_q <= '0;
						for (int i = 0; i < 4; i++) begin
							x_q[i] <= s_tdata[WORD_W*i +: WORD_W];
							k_q[i] <= key_q[i] ^ FK[i];
						end
						state_q <= keys_ready_q ? ST_FETCH : ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					k_q[0] <= k_q[1];
					k_q[1] <= k_q[2];
					k_q[2] <= k_q[3];
					k_q[3] <= k_new;
					cnt_q  <= cnt_nxt;
					if (cnt_q == rk_addr_t'(ROUNDS - 1)) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					x_q[0] <= x_q[1];
					x_q[1] <= x_q[2];
					x_q[2] <= x_q[3];
					x_q[3] <= x_new;
					cnt_q  <= cnt_nxt;
					if (cnt_q == rk_addr_t'(ROUNDS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold the result until the output register frees up
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q <= {x_q[0], x_q[1], x_q[2], x_q[3]};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (state_q == ST_DONE && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_we) begin
				keys_ready_q <= 1'b0;
			end else if (state_q == ST_EXPAND && cnt_q == rk_addr_t'(ROUNDS - 1)) begin
				keys_ready_q <= 1'b1;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

@@ rtl/sm4_chk.sv @@
module sm4_chk (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [sm4_pkg::DATA_W-1:0] m_tdata
);

	// one block at a time: no second transfer right after a taken one
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken again right after a transfer");

	// the input is still closed at a single check point after the taken block, not at every sample before it
	a_busy_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> ##32 !s_tready)
		else $error("input reopened before all rounds ran");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

bind sm4_block_cipher sm4_chk u_sm4_chk (.*);
